// ===== rtl/i2cmbe_pkg.sv =====
package i2cmbe_pkg;

    // command codes carried in the op field
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // configuration register indexes
    localparam int unsigned CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_HALF_PERIOD   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_STRETCH_LIMIT = 1'd1;

    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [15:0] HALF_PERIOD_RST   = 16'd15;
    localparam logic [15:0] STRETCH_LIMIT_RST = 16'd1000;

    // bit slots per byte; slot index 8 is the ACK slot
    localparam logic [3:0] ACK_SLOT = 4'd8;

    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 16;

endpackage

// ===== rtl/i2c_master_byte_engine.sv =====
// I2C master byte engine: one bus tick per input word.
// Input stream (s_*): each word is one tick and carries a command code, the
// byte to write, the ACK choice for reads and the sampled SCL/SDA levels.
// A command (start, stop, write byte, read byte) is taken only while idle;
// one arriving while busy is ignored, codes 0 and 5..7 just advance time.
// Output stream (m_*): exactly one result word per input word, giving the
// open-drain pull-downs for SCL/SDA, busy, a done pulse, the ACK seen on the
// last write, the last byte read and the timeout flag.
// The result of a word is registered when the word is accepted.
// Throughput: one word per cycle unless stalled; the whole tick update is a single
// pass of the state machine between the state registers and the result register.
// Stalls: the result register acts as the output stage; a new word is taken
// whenever it is empty or being drained, so m_tready low stalls s_tready.
// Reset (rst_n low, asynchronous): engine idle, lines released, flags clear,
// half_period = 15, stretch_limit = 1000.
// Configuration (cfg_we/cfg_addr/cfg_wdata) is to be written while idle.
module i2c_master_byte_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [i2cmbe_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [i2cmbe_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // command/tick words
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [2:0] op, [10:3] tx_byte, [11] send_ack, [12] scl_in, [13] sda_in, [15:14] zero
    input  logic [i2cmbe_pkg::IN_DATA_W-1:0]    s_tdata,
    // result words
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] scl_pull_low, [1] sda_pull_low, [2] busy_res, [3] done_res,
    // [4] acked, [12:5] rx_byte, [13] timed_out, [15:14] zero
    output logic [i2cmbe_pkg::OUT_DATA_W-1:0]   m_tdata
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST_A,
        PH_ST_B,
        PH_ST_C,
        PH_BIT_LOW,
        PH_BIT_WAIT,
        PH_BIT_HIGH,
        PH_SP_LOW,
        PH_SP_WAIT,
        PH_SP_HIGH,
        PH_SP_END
    } phase_t;

    // unpacked input word
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       scl_in;
    logic       sda_in;

    assign op       = s_tdata[2:0];
    assign tx_byte  = s_tdata[10:3];
    assign send_ack = s_tdata[11];
    assign scl_in   = s_tdata[12];
    assign sda_in   = s_tdata[13];

    // configuration
    logic [15:0] half_period_reg;
    logic [15:0] stretch_limit_reg;

    // engine state
    phase_t      phase_reg,         phase_next;
    logic [3:0]  bit_index_reg,     bit_index_next;
    logic [7:0]  shift_reg,         shift_next;
    logic [15:0] phase_timer_reg,   phase_timer_next;
    logic [15:0] stretch_timer_reg, stretch_timer_next;
    logic        scl_drive_reg,     scl_drive_next;
    logic        sda_drive_reg,     sda_drive_next;
    logic        ack_flag_reg,      ack_flag_next;
    logic        timeout_flag_reg,  timeout_flag_next;
    logic        ack_choice_reg,    ack_choice_next;
    logic        mode_read_reg,     mode_read_next;
    logic [7:0]  rx_last_reg,       rx_last_next;
    logic        done_next;

    // output stage
    logic                                out_valid_reg;
    logic [i2cmbe_pkg::OUT_DATA_W-1:0]   out_data_reg;
    logic [i2cmbe_pkg::OUT_DATA_W-1:0]   out_data_next;

    logic accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // timers: zero in either register behaves as one
    logic [15:0] hp_eff;
    logic [15:0] lim_eff;
    logic [15:0] phase_inc;
    logic [15:0] stretch_inc;
    logic        half_done;
    logic        stretch_out;

    assign hp_eff      = (half_period_reg == 16'd0) ? 16'd1 : half_period_reg;
    assign lim_eff     = (stretch_limit_reg == 16'd0) ? 16'd1 : stretch_limit_reg;
    assign phase_inc   = phase_timer_reg + 16'd1;
    assign stretch_inc = stretch_timer_reg + 16'd1;
    assign half_done   = (phase_inc >= hp_eff);
    assign stretch_out = (stretch_inc >= lim_eff);

    // SDA pull-down for the low half of a bit slot
    function automatic logic slot_sda(input logic [3:0] idx, input logic rd,
                                      input logic ack_ch, input logic [7:0] sh);
        logic [2:0] pos;
        pos = ~idx[2:0];
        if (idx >= i2cmbe_pkg::ACK_SLOT)
            return rd ? ack_ch : 1'b0;
        else if (rd)
            return 1'b0;
        else
            return ~sh[pos];
    endfunction

    logic [2:0] cur_pos;
    assign cur_pos = ~bit_index_reg[2:0];

    always_comb
    begin
        phase_next         = phase_reg;
        bit_index_next     = bit_index_reg;
        shift_next         = shift_reg;
        phase_timer_next   = phase_timer_reg;
        stretch_timer_next = stretch_timer_reg;
        scl_drive_next     = scl_drive_reg;
        sda_drive_next     = sda_drive_reg;
        ack_flag_next      = ack_flag_reg;
        timeout_flag_next  = timeout_flag_reg;
        ack_choice_next    = ack_choice_reg;
        mode_read_next     = mode_read_reg;
        rx_last_next       = rx_last_reg;
        done_next          = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (op inside {[i2cmbe_pkg::OP_START:i2cmbe_pkg::OP_READ]})
                begin
                    timeout_flag_next  = 1'b0;
                    phase_timer_next   = 16'd0;
                    stretch_timer_next = 16'd0;
                    if (op == i2cmbe_pkg::OP_START)
                    begin
                        sda_drive_next = 1'b0;
                        phase_next     = PH_ST_A;
                    end
                    else if (op == i2cmbe_pkg::OP_STOP)
                    begin
                        sda_drive_next = 1'b1;
                        phase_next     = PH_SP_LOW;
                    end
                    else
                    begin
                        mode_read_next = (op == i2cmbe_pkg::OP_READ);
                        bit_index_next = 4'd0;
                        if (op == i2cmbe_pkg::OP_WRITE)
                        begin
                            ack_flag_next = 1'b0;
                            shift_next    = tx_byte;
                        end
                        else
                        begin
                            ack_choice_next = send_ack;
                            shift_next      = 8'd0;
                        end
                        scl_drive_next = 1'b1;
                        sda_drive_next = slot_sda(4'd0, mode_read_next,
                                                  ack_choice_next, shift_next);
                        phase_next     = PH_BIT_LOW;
                    end
                end
            end
            PH_ST_A:
            begin
                phase_timer_next = half_done ? 16'd0 : phase_inc;
                if (half_done)
                begin
                    scl_drive_next = 1'b0;
                    phase_next     = PH_ST_B;
                end
            end
            PH_ST_B:
            begin
                phase_timer_next = half_done ? 16'd0 : phase_inc;
                if (half_done)
                begin
                    sda_drive_next = 1'b1;
                    phase_next     = PH_ST_C;
                end
            end
            PH_ST_C:
            begin
                phase_timer_next = half_done ? 16'd0 : phase_inc;
                if (half_done)
                begin
                    scl_drive_next = 1'b1;
                    phase_next     = PH_IDLE;
                    done_next      = 1'b1;
                end
            end
            PH_BIT_LOW:
            begin
                phase_timer_next = half_done ? 16'd0 : phase_inc;
                if (half_done)
                begin
                    scl_drive_next     = 1'b0;
                    stretch_timer_next = 16'd0;
                    phase_next         = PH_BIT_WAIT;
                end
            end
            PH_BIT_WAIT:
            begin
                if (scl_in)
                begin
                    phase_timer_next = 16'd0;
                    phase_next       = PH_BIT_HIGH;
                end
                else
                begin
                    stretch_timer_next = stretch_inc;
                    if (stretch_out)
                    begin
                        timeout_flag_next = 1'b1;
                        if (!mode_read_reg)
                        begin
                            // write aborts, lines left as they are
                            ack_flag_next = 1'b0;
                            phase_next    = PH_IDLE;
                            done_next     = 1'b1;
                        end
                        else if (bit_index_reg[3])
                        begin
                            scl_drive_next = 1'b1;
                            sda_drive_next = 1'b0;
                            rx_last_next   = shift_reg;
                            phase_next     = PH_IDLE;
                            done_next      = 1'b1;
                        end
                        else
                        begin
                            // read: skip remaining data bits, go to ACK slot
                            bit_index_next   = i2cmbe_pkg::ACK_SLOT;
                            scl_drive_next   = 1'b1;
                            sda_drive_next   = ack_choice_reg;
                            phase_timer_next = 16'd0;
                            phase_next       = PH_BIT_LOW;
                        end
                    end
                end
            end
            PH_BIT_HIGH:
            begin
                phase_timer_next = half_done ? 16'd0 : phase_inc;
                if (half_done)
                begin
                    if (bit_index_reg[3])
                    begin
                        if (mode_read_reg)
                        begin
                            scl_drive_next = 1'b1;
                            sda_drive_next = 1'b0;
                            rx_last_next   = shift_reg;
                        end
                        else
                        begin
                            ack_flag_next  = ~sda_in;
                            scl_drive_next = 1'b1;
                        end
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        if (mode_read_reg)
                            shift_next[cur_pos] = shift_reg[cur_pos] | sda_in;
                        bit_index_next = bit_index_reg + 4'd1;
                        scl_drive_next = 1'b1;
                        sda_drive_next = slot_sda(bit_index_next, mode_read_reg,
                                                  ack_choice_reg, shift_next);
                        phase_next     = PH_BIT_LOW;
                    end
                end
            end
            PH_SP_LOW:
            begin
                phase_timer_next = half_done ? 16'd0 : phase_inc;
                if (half_done)
                begin
                    scl_drive_next     = 1'b0;
                    stretch_timer_next = 16'd0;
                    phase_next         = PH_SP_WAIT;
                end
            end
            PH_SP_WAIT:
            begin
                if (scl_in)
                begin
                    phase_timer_next = 16'd0;
                    phase_next       = PH_SP_HIGH;
                end
                else
                begin
                    stretch_timer_next = stretch_inc;
                    if (stretch_out)
                    begin
                        // SDA stays pulled low
                        timeout_flag_next = 1'b1;
                        phase_next        = PH_IDLE;
                        done_next         = 1'b1;
                    end
                end
            end
            PH_SP_HIGH:
            begin
                phase_timer_next = half_done ? 16'd0 : phase_inc;
                if (half_done)
                begin
                    sda_drive_next = 1'b0;
                    phase_next     = PH_SP_END;
                end
            end
            PH_SP_END:
            begin
                phase_timer_next = half_done ? 16'd0 : phase_inc;
                if (half_done)
                begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    assign out_data_next = {2'b00, timeout_flag_next, rx_last_next, ack_flag_next,
                            done_next, (phase_next != PH_IDLE),
                            sda_drive_next, scl_drive_next};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg   <= i2cmbe_pkg::HALF_PERIOD_RST;
            stretch_limit_reg <= i2cmbe_pkg::STRETCH_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                i2cmbe_pkg::REG_HALF_PERIOD:   half_period_reg   <= cfg_wdata;
                i2cmbe_pkg::REG_STRETCH_LIMIT: stretch_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // engine state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            bit_index_reg     <= 4'd0;
            shift_reg         <= 8'd0;
            phase_timer_reg   <= 16'd0;
            stretch_timer_reg <= 16'd0;
            scl_drive_reg     <= 1'b0;
            sda_drive_reg     <= 1'b0;
            ack_flag_reg      <= 1'b0;
            timeout_flag_reg  <= 1'b0;
            ack_choice_reg    <= 1'b0;
            mode_read_reg     <= 1'b0;
            rx_last_reg       <= 8'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg         <= phase_next;
                bit_index_reg     <= bit_index_next;
                shift_reg         <= shift_next;
                phase_timer_reg   <= phase_timer_next;
                stretch_timer_reg <= stretch_timer_next;
                scl_drive_reg     <= scl_drive_next;
                sda_drive_reg     <= sda_drive_next;
                ack_flag_reg      <= ack_flag_next;
                timeout_flag_reg  <= timeout_flag_next;
                ack_choice_reg    <= ack_choice_next;
                mode_read_reg     <= mode_read_next;
                rx_last_reg       <= rx_last_next;
                out_valid_reg     <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload of the result register, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

    // engine only moves on an accepted tick
    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(phase_reg) && $stable(shift_reg) && $stable(bit_index_reg))
        else $error("engine state moved without an accepted word");

    // idle ticks with no command keep the engine idle
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_IDLE &&
        !(op == i2cmbe_pkg::OP_START || op == i2cmbe_pkg::OP_STOP ||
          op == i2cmbe_pkg::OP_WRITE || op == i2cmbe_pkg::OP_READ)
        |=> phase_reg == PH_IDLE)
        else $error("engine left idle without a command");

    // slot counter never passes the ACK slot during a byte
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BIT_LOW || phase_reg == PH_BIT_WAIT || phase_reg == PH_BIT_HIGH)
        |-> bit_index_reg <= i2cmbe_pkg::ACK_SLOT)
        else $error("bit slot index out of range");

    // end of a start condition leaves SCL and SDA pulled low and the engine idle
    a_start_end: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_ST_C && half_done
        |=> phase_reg == PH_IDLE && scl_drive_reg && sda_drive_reg)
        else $error("start condition did not finish with SCL low");

    // a done pulse in a result always comes with busy clear
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && done_next |=> m_tvalid && m_tdata[3] && !m_tdata[2])
        else $error("done reported while still busy");

endmodule
